// ===== src/bust_pkg.sv =====
// Package for the bounded unique set table: shared constants, codes and the
// command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bust_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = 5;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_EXISTS = 2'd1,
      ST_FULL   = 2'd2,
      ST_MISS   = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       idx_inc;
      logic       ram_rd;
      logic       rd_next;
      logic       ram_we;
      logic       wr_shift;
      logic       count_inc;
      logic       count_dec;
      logic       count_clear;
      logic       found_set;
      logic       res_we;
      logic       res_hit;
      status_type res_status;
      logic       rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       count_zero;
      logic       match;
      logic       scan_last;
      logic       shift_more;
      logic       full;
      logic       found;
      logic       rsp_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== src/bust_req_if.sv =====
// Request channel of the set table: valid/ready plus action and value.
// Depends on bust_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bust_req_if;
   logic                                valid;
   logic                                ready;
   bust_pkg::action_type                action;
   logic signed [bust_pkg::VALUE_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== src/bust_rsp_if.sv =====
// Response channel of the set table: valid/ready plus hit, status and count.
// Depends on bust_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bust_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   bust_pkg::status_type         status;
   logic [bust_pkg::COUNT_W-1:0] count;

   modport source (output valid, output hit, output status, output count, input ready);
   modport sink   (input valid, input hit, input status, input count, output ready);
endinterface

`default_nettype wire

// ===== src/bounded_unique_set_table_top.sv =====
// Bounded unique set table: one item at a time; lookup, insert, delete, clear.
// After acceptance an item passes a start state, a read and a compare state per
// entry scanned in the RAM (up to the count), and a resolve state; a hit delete then
// reads and writes back each entry moved down; the RAM has a single read port.
// A new item is taken only in the cycle after a result enters the output register.
// Synchronous reset empties the set at once; entry contents are left unwritten.
`timescale 1ns / 1ps
`default_nettype none

module bounded_unique_set_table_top #(
   parameter int CAPACITY = bust_pkg::CAPACITY_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bust_req_if.sink    req,
   bust_rsp_if.source  rsp
);

   bust_pkg::dp_cmd_type cmd;
   bust_pkg::dp_sts_type sts;

   bust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bust_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_action (req.action),
      .req_value  (req.value),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_hit    (rsp.hit),
      .rsp_status (rsp.status),
      .rsp_count  (rsp.count)
   );

endmodule

`default_nettype wire

// ===== src/bust_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bust_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/bust_dp.sv =====
// Datapath of the set table: entry RAM, count, scan index, item and result
// registers, and the output register of the response channel.
// Depends on bust_pkg and bust_ram.
`timescale 1ns / 1ps
`default_nettype none

module bust_dp #(
   parameter int CAPACITY = bust_pkg::CAPACITY_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bust_pkg::dp_cmd_type                cmd,
   output bust_pkg::dp_sts_type                     sts,
   input  wire bust_pkg::action_type                req_action,
   input  wire logic signed [bust_pkg::VALUE_W-1:0] req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_hit,
   output bust_pkg::status_type                     rsp_status,
   output logic [bust_pkg::COUNT_W-1:0]             rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   bust_pkg::action_type            action_ff;
   logic [bust_pkg::VALUE_W-1:0]    value_ff;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   idx_next;
   logic                            found_ff;
   logic                            hit_ff;
   bust_pkg::status_type            status_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   bust_pkg::status_type            rsp_status_ff;
   logic [bust_pkg::COUNT_W-1:0]    rsp_count_ff;

   logic [AW-1:0]                   rd_addr, wr_addr;
   logic [bust_pkg::VALUE_W-1:0]    rd_data, wr_data;

   assign idx_next = idx_ff + CW'(1);

   // Reads go to the scan index, or one above it while compacting.
   assign rd_addr = cmd.rd_next ? idx_next[AW-1:0] : idx_ff[AW-1:0];
   // An append writes at the count; a compaction step writes back one place down.
   assign wr_addr = cmd.wr_shift ? idx_ff[AW-1:0] : count_ff[AW-1:0];
   assign wr_data = cmd.wr_shift ? rd_data : value_ff;

   bust_ram #(
      .WIDTH (bust_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .we      (cmd.ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.found_set) begin
            found_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         value_ff  <= req_value;
      end
      if (cmd.res_we) begin
         hit_ff    <= cmd.res_hit;
         status_ff <= cmd.res_status;
      end
      if (cmd.rsp_load) begin
         rsp_hit_ff    <= hit_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= bust_pkg::COUNT_W'(count_ff);
      end
   end

   always_comb begin
      sts.action     = action_ff;
      sts.count_zero = (count_ff == '0);
      sts.match      = (rd_data == value_ff);
      sts.scan_last  = (idx_next == count_ff);
      sts.shift_more = (idx_next < count_ff);
      sts.full       = (count_ff == CW'(CAPACITY));
      sts.found      = found_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

`default_nettype wire

// ===== src/bust_ctrl.sv =====
// Controller of the set table: sequences the scan, the append or the
// compaction, and the hand-off of each result to the output register.
// Depends on bust_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bust_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output bust_pkg::dp_cmd_type      cmd,
   input  wire bust_pkg::dp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_READ,
      S_CMP,
      S_RESOLVE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.res_status = bust_pkg::ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (sts.action == bust_pkg::ACT_CLEAR || sts.count_zero) begin
               state_in = S_RESOLVE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            // The index stays on the first match, which is where compaction starts.
            priority if (sts.match) begin
               cmd.found_set = 1'b1;
               state_in      = S_RESOLVE;
            end else if (sts.scan_last) begin
               state_in = S_RESOLVE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_READ;
            end
         end
         S_RESOLVE: begin
            cmd.res_we  = 1'b1;
            cmd.res_hit = sts.found;
            state_in    = S_FINISH;
            unique case (sts.action)
               bust_pkg::ACT_LOOKUP: begin
                  cmd.res_status = sts.found ? bust_pkg::ST_DONE : bust_pkg::ST_MISS;
               end
               bust_pkg::ACT_INSERT: begin
                  priority if (sts.found) begin
                     cmd.res_status = bust_pkg::ST_EXISTS;
                  end else if (sts.full) begin
                     cmd.res_status = bust_pkg::ST_FULL;
                  end else begin
                     cmd.ram_we     = 1'b1;
                     cmd.count_inc  = 1'b1;
                     cmd.res_status = bust_pkg::ST_DONE;
                  end
               end
               bust_pkg::ACT_DELETE: begin
                  if (sts.found) begin
                     cmd.res_status = bust_pkg::ST_DONE;
                     state_in       = S_SHIFT_RD;
                  end else begin
                     cmd.res_status = bust_pkg::ST_MISS;
                  end
               end
               bust_pkg::ACT_CLEAR: begin
                  cmd.res_hit     = 1'b0;
                  cmd.count_clear = 1'b1;
                  cmd.res_status  = bust_pkg::ST_DONE;
               end
               default: begin
                  cmd.res_status = bust_pkg::ST_DONE;
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (sts.shift_more) begin
               cmd.ram_rd  = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.ram_we   = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bust_checker.sv =====
// Port-level checks for the set table, attached to the top level by bind.
// Depends on bust_pkg and bounded_unique_set_table_top.
`timescale 1ns / 1ps
`default_nettype none

module bust_checker #(
   parameter int CAPACITY = bust_pkg::CAPACITY_DEF
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_hit,
   input wire logic [1:0]                   rsp_status,
   input wire logic [bust_pkg::COUNT_W-1:0] rsp_count
);

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_status)
         && $stable(rsp_count))
      else $error("result changed while stalled");

   // An item is worked on alone: no second item right after one is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in progress");

   // A full table refusal reports no hit and a full count.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bust_pkg::ST_FULL |->
         !rsp_hit && rsp_count == bust_pkg::COUNT_W'(CAPACITY))
      else $error("full status without full count");

   a_exists_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bust_pkg::ST_EXISTS |-> rsp_hit)
      else $error("existing-value status without hit");

   a_miss_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bust_pkg::ST_MISS |-> !rsp_hit)
      else $error("miss status with hit");

endmodule

bind bounded_unique_set_table_top bust_checker #(
   .CAPACITY (CAPACITY)
) u_bust_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_hit    (rsp.hit),
   .rsp_status (rsp.status),
   .rsp_count  (rsp.count)
);

`default_nettype wire
